>>> src/istm_pkg.sv
// Shared types, constants and the reciprocal-root table function for the
// inverse-square key travel mapper. Depends on nothing.
package istm_pkg;

  // Fixed field widths.
  localparam int unsigned READING_BITS = 12;
  localparam int unsigned TRAVEL_BITS  = 10;
  localparam int unsigned KEY_BITS     = 8;
  localparam int unsigned CFG_BITS     = 12;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned WORD_BITS    = 32;
  localparam int unsigned ROM_BITS     = 16;

  // Root is Q.16: sqrt(v << 32) has ROOT_W integer bits, one more after rounding.
  localparam int unsigned ROOT_W  = (READING_BITS + 32 + 1) / 2;
  localparam int unsigned SQ_W    = ROOT_W + 1;
  localparam int unsigned NUM_W   = TRAVEL_BITS + SQ_W;
  localparam int unsigned NSR_W   = NUM_W + SQ_W;
  localparam int unsigned DIVD_W  = NSR_W + 2;
  localparam int unsigned DIVS_W  = SQ_W + 16 + 1;

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_TRAVEL  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REST_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOTTOM_FLR  = 2'd2;

  typedef enum logic [1:0] {
    ST_MAPPED  = 2'd0,
    ST_CAL_OK  = 2'd1,
    ST_CAL_REJ = 2'd2,
    ST_BAD_KEY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SMP_RD,
    S_SMP_FIN,
    S_CAL_CHK,
    S_CAL_SR,
    S_CAL_SB,
    S_CAL_MUL1,
    S_CAL_MUL2,
    S_CAL_D1,
    S_CAL_D2,
    S_CAL_WR,
    S_BAD
  } state_e;

  typedef struct packed {
    logic                    func;
    logic [KEY_BITS-1:0]     key_index;
    logic [READING_BITS-1:0] sample_reading;
    logic [READING_BITS-1:0] new_rest_reading;
    logic [READING_BITS-1:0] new_bottom_reading;
  } in_beat_t;

  typedef struct packed {
    logic [TRAVEL_BITS-1:0] travel;
    logic [1:0]             status;
  } out_beat_t;

  typedef struct packed {
    logic [READING_BITS-1:0] rest;
    logic [READING_BITS-1:0] bottom;
    logic [WORD_BITS-1:0]    icpt;
    logic [WORD_BITS-1:0]    slope;
  } entry_t;

  // round(2^f / sqrt(i)), entry 0 saturated; evaluated at elaboration only.
  function automatic logic [ROM_BITS-1:0] rom_entry(int unsigned i, int unsigned f);
    longint unsigned lim;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned ii;
    ii  = 64'(i);
    lim = 64'd1 << (2 * f);
    lo  = 0;
    hi  = 64'd1 << f;
    if (i == 0) return {ROM_BITS{1'b1}};
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid * ii <= lim) lo = mid;
      else hi = mid - 1;
    end
    if ((2 * lo + 1) * (2 * lo + 1) * ii < 4 * lim) lo = lo + 1;
    return lo[ROM_BITS-1:0];
  endfunction

endpackage

>>> src/istm_intf.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on istm_pkg.
interface istm_in_if;
  logic               valid;
  logic               ready;
  istm_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface istm_out_if;
  logic                valid;
  logic                ready;
  istm_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/inverse_square_key_travel_mapper_unit.sv
// Top level of the inverse-square key travel mapper: per-key state memory,
// sequencer, reciprocal-root table and result register. Depends on istm_pkg,
// istm_intf, istm_sqrt and istm_div.
//
// A sample beat runs in order: the accepting edge reads the key memory and
// the reciprocal-root table, S_SMP_RD registers the slope product and
// S_SMP_FIN clamps, subtracts and loads the result; the sequencer is then
// idle and takes the next beat. A calibration beat runs the bit-serial
// square-root unit twice and then the bit-serial divider twice before it
// loads its result; one that fails its checks goes from S_CAL_CHK straight to
// S_CAL_WR, and a bad key goes to S_BAD. A result that waits on the output
// holds back the load until the output is free. The key memory needs no
// clearing after reset: a valid flag per key makes a never-written key
// read as rest 0, bottom 4095, intercept 0 and slope 0. A new beat is
// taken while the last result still waits on the output.
module inverse_square_key_travel_mapper_unit #(
  parameter int unsigned KEY_COUNT          = 64,
  parameter int unsigned INDEX_DROP_BITS    = 4,
  parameter int unsigned FRACTION_BITS      = 15,
  parameter int unsigned TABLE_LAST_READING = 4095
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [istm_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [istm_pkg::CFG_BITS-1:0]         cfg_data_i,
  istm_in_if.sink                               in_if,
  istm_out_if.source                            out_if
);
  localparam int unsigned RB        = istm_pkg::READING_BITS;
  localparam int unsigned TB        = istm_pkg::TRAVEL_BITS;
  localparam int unsigned KEY_AW    = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned ROM_DEPTH = (TABLE_LAST_READING >> INDEX_DROP_BITS) + 1;
  localparam int unsigned ROM_AW    = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;
  localparam int unsigned PROD_W    = istm_pkg::WORD_BITS + istm_pkg::ROM_BITS + 1;
  localparam int unsigned SQ_W      = istm_pkg::SQ_W;
  localparam int unsigned NUM_W     = istm_pkg::NUM_W;
  localparam int unsigned NSR_W     = istm_pkg::NSR_W;
  localparam int unsigned DIVD_W    = istm_pkg::DIVD_W;
  localparam int unsigned DIVS_W    = istm_pkg::DIVS_W;
  localparam int unsigned WB        = istm_pkg::WORD_BITS;

  // Configuration registers.
  logic [TB-1:0] max_travel_q;
  logic [RB-1:0] rest_limit_q, bottom_floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_travel_q   <= TB'(255);
      rest_limit_q   <= {RB{1'b1}};
      bottom_floor_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        istm_pkg::CFG_MAX_TRAVEL: max_travel_q   <= cfg_data_i[TB-1:0];
        istm_pkg::CFG_REST_LIMIT: rest_limit_q   <= cfg_data_i[RB-1:0];
        istm_pkg::CFG_BOTTOM_FLR: bottom_floor_q <= cfg_data_i[RB-1:0];
        default: ;
      endcase
    end
  end

  // Reciprocal-root table, constant at elaboration.
  logic [istm_pkg::ROM_BITS-1:0] rom_w [2**ROM_AW];
  for (genvar g = 0; g < 2**ROM_AW; g++) begin : g_rom
    if (g < ROM_DEPTH) begin : g_used
      assign rom_w[g] = istm_pkg::rom_entry(g, FRACTION_BITS);
    end else begin : g_pad
      assign rom_w[g] = '0;
    end
  end

  istm_pkg::state_e state_q, state_d;
  istm_pkg::in_beat_t item_q;
  istm_pkg::entry_t   mem_q [KEY_COUNT];
  istm_pkg::entry_t   rd_q, ent, wr_ent;
  logic [KEY_COUNT-1:0] vld_q;
  logic                 rd_vld_q;
  logic [istm_pkg::ROM_BITS-1:0] rom_q;
  logic                 beyond_q;

  logic          accept, bad_key, out_free, out_load, mem_we;
  logic [RB-1:0] idx_full;
  logic [KEY_AW-1:0] key_a, item_a;
  istm_pkg::out_beat_t res_d, out_q;
  logic          out_valid_q;

  logic [PROD_W-1:0] prod_full, prod_q, diff;
  logic [SQ_W-1:0]   sr_q, sb_q, den_q;
  logic [NUM_W-1:0]  num_q;
  logic [NSR_W-1:0]  nsr_q;
  logic              den_ok_q, cal_ok_q;
  logic [WB-1:0]     icpt_q, slope_q, quo_sat;
  logic              cal_valid;

  logic                sq_start, sq_done, dv_start, dv_done;
  logic [RB-1:0]       sq_val;
  logic [SQ_W-1:0]     sq_root;
  logic [DIVD_W-1:0]   dv_dividend, dv_quo;
  logic [DIVS_W-1:0]   dv_divisor;

  assign accept   = in_if.valid && in_if.ready;
  assign bad_key  = {1'b0, in_if.data.key_index} >= (istm_pkg::KEY_BITS + 1)'(KEY_COUNT);
  assign idx_full = in_if.data.sample_reading >> INDEX_DROP_BITS;
  assign key_a    = KEY_AW'(in_if.data.key_index);
  assign item_a   = KEY_AW'(item_q.key_index);
  assign out_free = !out_valid_q || out_if.ready;
  assign in_if.ready = (state_q == istm_pkg::S_IDLE);

  // Key memory: read on acceptance, written at the end of a calibration.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q     <= mem_q[key_a];
      rom_q    <= rom_w[idx_full[ROM_AW-1:0]];
      beyond_q <= idx_full > RB'(ROM_DEPTH - 1);
      item_q   <= in_if.data;
    end
    if (mem_we) mem_q[item_a] <= wr_ent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (accept) rd_vld_q <= vld_q[key_a];
      if (mem_we) vld_q[item_a] <= 1'b1;
    end
  end

  // Entry never written reads as its reset value.
  always_comb begin
    if (rd_vld_q) ent = rd_q;
    else ent = '{rest: '0, bottom: {RB{1'b1}}, icpt: '0, slope: '0};
  end

  always_comb begin
    wr_ent        = ent;
    wr_ent.rest   = item_q.new_rest_reading;
    wr_ent.bottom = item_q.new_bottom_reading;
    if (cal_ok_q) begin
      wr_ent.icpt  = icpt_q;
      wr_ent.slope = slope_q;
    end
  end

  // Sample path arithmetic.
  assign prod_full = PROD_W'(ent.slope) * PROD_W'(rom_q) + (PROD_W'(1) << (FRACTION_BITS - 1));
  assign diff      = PROD_W'(ent.icpt) - prod_q;

  assign cal_valid = (item_q.new_rest_reading != '0) && (item_q.new_bottom_reading != '0) &&
                     (item_q.new_rest_reading < item_q.new_bottom_reading) &&
                     (item_q.new_rest_reading <= rest_limit_q) &&
                     (item_q.new_bottom_reading >= bottom_floor_q);

  assign quo_sat = (|dv_quo[DIVD_W-1:WB]) ? {WB{1'b1}} : dv_quo[WB-1:0];

  // Sequencer.
  always_comb begin
    state_d        = state_q;
    sq_start       = 1'b0;
    dv_start       = 1'b0;
    sq_val         = item_q.new_rest_reading;
    dv_dividend    = DIVD_W'({num_q, 1'b0}) + DIVD_W'(den_q);
    dv_divisor     = DIVS_W'({den_q, 1'b0});
    out_load       = 1'b0;
    mem_we         = 1'b0;
    res_d.travel   = '0;
    res_d.status   = istm_pkg::ST_MAPPED;
    case (state_q)
      istm_pkg::S_IDLE: begin
        if (accept) begin
          if (bad_key) state_d = istm_pkg::S_BAD;
          else if (in_if.data.func) state_d = istm_pkg::S_CAL_CHK;
          else state_d = istm_pkg::S_SMP_RD;
        end
      end
      istm_pkg::S_SMP_RD: state_d = istm_pkg::S_SMP_FIN;
      istm_pkg::S_SMP_FIN: begin
        if (item_q.sample_reading <= ent.rest) res_d.travel = '0;
        else if (item_q.sample_reading >= ent.bottom) res_d.travel = max_travel_q;
        else if (beyond_q) res_d.travel = max_travel_q;
        else if (prod_q >= PROD_W'(ent.icpt)) res_d.travel = '0;
        else if (diff >= PROD_W'(max_travel_q)) res_d.travel = max_travel_q;
        else res_d.travel = diff[TB-1:0];
        if (out_free) begin
          out_load = 1'b1;
          state_d  = istm_pkg::S_IDLE;
        end
      end
      istm_pkg::S_CAL_CHK: begin
        if (cal_valid) begin
          sq_start = 1'b1;
          state_d  = istm_pkg::S_CAL_SR;
        end else begin
          state_d = istm_pkg::S_CAL_WR;
        end
      end
      istm_pkg::S_CAL_SR: begin
        sq_val = item_q.new_bottom_reading;
        if (sq_done) begin
          sq_start = 1'b1;
          state_d  = istm_pkg::S_CAL_SB;
        end
      end
      istm_pkg::S_CAL_SB: if (sq_done) state_d = istm_pkg::S_CAL_MUL1;
      istm_pkg::S_CAL_MUL1: state_d = istm_pkg::S_CAL_MUL2;
      istm_pkg::S_CAL_MUL2: begin
        if (den_ok_q) begin
          dv_start = 1'b1;
          state_d  = istm_pkg::S_CAL_D1;
        end else begin
          state_d = istm_pkg::S_CAL_WR;
        end
      end
      istm_pkg::S_CAL_D1: begin
        dv_dividend = DIVD_W'({nsr_q, 1'b0}) + DIVD_W'({den_q, 16'd0});
        dv_divisor  = DIVS_W'({den_q, 17'd0});
        if (dv_done) begin
          dv_start = 1'b1;
          state_d  = istm_pkg::S_CAL_D2;
        end
      end
      istm_pkg::S_CAL_D2: if (dv_done) state_d = istm_pkg::S_CAL_WR;
      istm_pkg::S_CAL_WR: begin
        res_d.status = cal_ok_q ? istm_pkg::ST_CAL_OK : istm_pkg::ST_CAL_REJ;
        if (out_free) begin
          out_load = 1'b1;
          mem_we   = 1'b1;
          state_d  = istm_pkg::S_IDLE;
        end
      end
      istm_pkg::S_BAD: begin
        res_d.status = istm_pkg::ST_BAD_KEY;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = istm_pkg::S_IDLE;
        end
      end
      default: state_d = istm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= istm_pkg::S_IDLE;
    else state_q <= state_d;
  end

  // Datapath registers of the sample and calibration steps.
  always_ff @(posedge clk_i) begin
    if (state_q == istm_pkg::S_SMP_RD) prod_q <= prod_full >> FRACTION_BITS;
    if (state_q == istm_pkg::S_CAL_CHK) cal_ok_q <= 1'b0;
    if (state_q == istm_pkg::S_CAL_SR && sq_done) sr_q <= sq_root;
    if (state_q == istm_pkg::S_CAL_SB && sq_done) sb_q <= sq_root;
    if (state_q == istm_pkg::S_CAL_MUL1) begin
      num_q    <= NUM_W'(max_travel_q) * NUM_W'(sb_q);
      den_q    <= sb_q - sr_q;
      den_ok_q <= sb_q > sr_q;
    end
    if (state_q == istm_pkg::S_CAL_MUL2) nsr_q <= NSR_W'(num_q) * NSR_W'(sr_q);
    if (state_q == istm_pkg::S_CAL_D1 && dv_done) icpt_q <= quo_sat;
    if (state_q == istm_pkg::S_CAL_D2 && dv_done) begin
      slope_q  <= quo_sat;
      cal_ok_q <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_load) out_valid_q <= 1'b1;
    else if (out_if.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_d;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  istm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (sq_val),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  istm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_dividend),
    .divisor_i  (dv_divisor),
    .done_o     (dv_done),
    .quo_o      (dv_quo)
  );
endmodule

>>> src/istm_sqrt.sv
// Iterative square root, one root bit per cycle: round(sqrt(v) * 2^16).
// Depends on istm_pkg.
module istm_sqrt (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [istm_pkg::READING_BITS-1:0]   val_i,
  output logic                                done_o,
  output logic [istm_pkg::SQ_W-1:0]           root_o
);
  localparam int unsigned RW   = istm_pkg::ROOT_W;
  localparam int unsigned XW   = 2 * RW;
  localparam int unsigned REMW = RW + 4;
  localparam int unsigned CW   = $clog2(RW + 1);

  logic [XW-1:0]   x_q;
  logic [REMW-1:0] rem_q;
  logic [RW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q;
  logic [istm_pkg::SQ_W-1:0] res_q;

  logic [REMW-1:0] rem_sh, trial, rem_n;
  logic [RW-1:0]   root_n;

  // One digit step: bring down two bits, try (root << 2) | 1.
  always_comb begin
    rem_sh = {rem_q[REMW-3:0], x_q[XW-1 -: 2]};
    trial  = REMW'({root_q, 2'b01});
    if (rem_sh >= trial) begin
      rem_n  = rem_sh - trial;
      root_n = {root_q[RW-2:0], 1'b1};
    end else begin
      rem_n  = rem_sh;
      root_n = {root_q[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(RW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath; final step rounds up when the remainder exceeds the root.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= XW'({val_i, 32'd0});
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[XW-3:0], 2'b00};
      rem_q  <= rem_n;
      root_q <= root_n;
      if (cnt_q == CW'(RW - 1)) begin
        res_q <= (rem_n > REMW'(root_n)) ? istm_pkg::SQ_W'(root_n) + istm_pkg::SQ_W'(1)
                                         : istm_pkg::SQ_W'(root_n);
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q;
endmodule

>>> src/istm_div.sv
// Restoring divider, one quotient bit per cycle, shared by both calibration
// quotients. Depends on istm_pkg.
module istm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [istm_pkg::DIVD_W-1:0]    dividend_i,
  input  logic [istm_pkg::DIVS_W-1:0]    divisor_i,
  output logic                           done_o,
  output logic [istm_pkg::DIVD_W-1:0]    quo_o
);
  localparam int unsigned QW = istm_pkg::DIVD_W;
  localparam int unsigned DW = istm_pkg::DIVS_W;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [QW-1:0] quo_q;
  logic [DW-1:0] rem_q, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   rem_sh;
  logic          ge;

  // Shift one dividend bit into the partial remainder and compare.
  always_comb begin
    rem_sh = {rem_q, quo_q[QW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[QW-2:0], ge};
      rem_q <= ge ? DW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
